[src/gas_alarm_frame_monitor_top_defines.svh]
// assertion macros used by the checker file
`ifndef GAS_ALARM_FRAME_MONITOR_TOP_DEFINES_SVH
`define GAS_ALARM_FRAME_MONITOR_TOP_DEFINES_SVH

// same-cycle implication, sampled on aclk, off during reset
`define GAFM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gafm check failed");

// next-cycle implication, sampled on aclk, off during reset
`define GAFM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gafm check failed");

`endif

[src/gafm_pkg.sv]
package gafm_pkg;

    localparam int FRAME_LEN_DEF = 7;

    localparam int PPM_HI_IDX = 3;
    localparam int PPM_LO_IDX = 4;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // item kinds
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register indexes
    localparam logic [1:0] REG_WARN_PPM     = 2'd0;
    localparam logic [1:0] REG_DANGER_PPM   = 2'd1;
    localparam logic [1:0] REG_REPEAT_TICKS = 2'd2;
    localparam logic [1:0] REG_HEADER_BYTE  = 2'd3;

    localparam logic [15:0] WARN_PPM_RST     = 16'd250;
    localparam logic [15:0] DANGER_PPM_RST   = 16'd400;
    localparam logic [4:0]  REPEAT_TICKS_RST = 5'd20;
    localparam logic [7:0]  HEADER_BYTE_RST  = 8'd2;

    // alarm commands
    localparam logic [2:0] CMD_SILENCE      = 3'd0;
    localparam logic [2:0] CMD_SPEAK        = 3'd1;
    localparam logic [2:0] CMD_SHORT_BEEP   = 3'd2;
    localparam logic [2:0] CMD_RAPID_SPEECH = 3'd3;
    localparam logic [2:0] CMD_RAPID_BEEP   = 3'd4;

    // relay actions
    localparam logic [1:0] RELAY_NONE  = 2'd0;
    localparam logic [1:0] RELAY_OPEN  = 2'd1;
    localparam logic [1:0] RELAY_CLOSE = 2'd2;

    // frame status
    localparam logic [2:0] STATUS_NONE       = 3'd0;
    localparam logic [2:0] STATUS_OK         = 3'd1;
    localparam logic [2:0] STATUS_BAD_HEADER = 3'd2;
    localparam logic [2:0] STATUS_CRC_ERROR  = 3'd3;
    localparam logic [2:0] STATUS_INCOMPLETE = 3'd4;
    localparam logic [2:0] STATUS_NO_REPLY   = 3'd5;

    // alarm levels
    localparam logic [1:0] LEVEL_SAFE   = 2'd0;
    localparam logic [1:0] LEVEL_WARN   = 2'd1;
    localparam logic [1:0] LEVEL_DANGER = 2'd2;

    // display band upper limits, and the lower limit of band 8
    localparam logic [15:0] BAND0_MAX = 16'd5;
    localparam logic [15:0] BAND1_MAX = 16'd30;
    localparam logic [15:0] BAND2_MAX = 16'd100;
    localparam logic [15:0] BAND3_MAX = 16'd150;
    localparam logic [15:0] BAND4_MAX = 16'd200;
    localparam logic [15:0] BAND5_MAX = 16'd250;
    localparam logic [15:0] BAND6_MAX = 16'd300;
    localparam logic [15:0] BAND7_MAX = 16'd400;
    localparam logic [15:0] BAND8_MIN = 16'd500;

    typedef struct packed {
        logic [2:0]  status;
        logic        ok;
        logic [15:0] ppm;
    } rx_result_t;

    typedef struct packed {
        logic        cmd_valid;
        logic [2:0]  alarm_cmd;
        logic [1:0]  relay_action;
        logic [15:0] ppm_value;
        logic [3:0]  display_code;
        logic [1:0]  alarm_level;
    } alarm_result_t;

    typedef struct packed {
        logic [15:0] warn_ppm;
        logic [15:0] danger_ppm;
        logic [4:0]  repeat_ticks;
    } alarm_cfg_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [3:0] band_code(input logic [15:0] ppm, input logic [3:0] prev);
        logic [3:0] code;
        priority if (ppm <= BAND0_MAX) code = 4'd0;
        else if (ppm <= BAND1_MAX) code = 4'd1;
        else if (ppm <= BAND2_MAX) code = 4'd2;
        else if (ppm <= BAND3_MAX) code = 4'd3;
        else if (ppm <= BAND4_MAX) code = 4'd4;
        else if (ppm <= BAND5_MAX) code = 4'd5;
        else if (ppm <= BAND6_MAX) code = 4'd6;
        else if (ppm <= BAND7_MAX) code = 4'd7;
        else if (ppm > BAND8_MIN) code = 4'd8;
        else code = prev;
        return code;
    endfunction

endpackage

[src/gas_alarm_frame_monitor_top.sv]
// Gas alarm frame monitor.
// Input channel (s_valid/s_ready): one item per handshake, either a sensor
// reply byte (s_op = 0, s_rx_byte) or a poll tick (s_op = 1, s_power_on).
// Result channel (m_valid/m_ready): exactly one result item per input item,
// in order: command, relay action, held ppm, display code, frame status and
// alarm level.
// Configuration: cfg_wr_en with cfg_index 0..3 writes warn_ppm, danger_ppm,
// repeat_ticks or header_byte from cfg_wdata; write only while no item
// is in flight.
// Throughput: one item per cycle while the receiver keeps m_ready high;
// the CRC byte update and the alarm machine settle between the input
// register and the result register.
// Reset (aresetn low, synchronous): both registers empty, receiver waiting
// for a header byte, ppm, display code, alarm level and counters cleared,
// configuration back to its defaults.
// Receiver stall: the result register holds, the input register takes one
// more item, then s_ready drops until m_ready frees the result register.
module gas_alarm_frame_monitor_top #(
    parameter int FRAME_LEN = gafm_pkg::FRAME_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_op,
    input  logic [7:0]  s_rx_byte,
    input  logic        s_power_on,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_cmd_valid,
    output logic [2:0]  m_alarm_cmd,
    output logic [1:0]  m_relay_action,
    output logic [15:0] m_ppm_value,
    output logic [3:0]  m_display_code,
    output logic [2:0]  m_frame_status,
    output logic [1:0]  m_alarm_level,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic        in_valid_reg, in_valid_next;
    logic        op_reg;
    logic [7:0]  byte_reg;
    logic        power_reg;
    logic        out_valid_reg, out_valid_next;
    logic        step;

    logic [15:0] warn_ppm_reg;
    logic [15:0] danger_ppm_reg;
    logic [4:0]  repeat_ticks_reg;
    logic [7:0]  header_byte_reg;

    gafm_pkg::rx_result_t    rx_result;
    gafm_pkg::alarm_cfg_t    alarm_cfg;
    gafm_pkg::alarm_result_t alarm_result;
    gafm_pkg::alarm_result_t result_reg;
    logic [2:0]              status_reg;

    assign step    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || step;

    assign in_valid_next  = (s_valid && s_ready) ? 1'b1 : (step ? 1'b0 : in_valid_reg);
    assign out_valid_next = step ? 1'b1 : (m_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg <= s_op;
            byte_reg <= s_rx_byte;
            power_reg <= s_power_on;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            warn_ppm_reg <= gafm_pkg::WARN_PPM_RST;
            danger_ppm_reg <= gafm_pkg::DANGER_PPM_RST;
            repeat_ticks_reg <= gafm_pkg::REPEAT_TICKS_RST;
            header_byte_reg <= gafm_pkg::HEADER_BYTE_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                gafm_pkg::REG_WARN_PPM:     warn_ppm_reg <= cfg_wdata;
                gafm_pkg::REG_DANGER_PPM:   danger_ppm_reg <= cfg_wdata;
                gafm_pkg::REG_REPEAT_TICKS: repeat_ticks_reg <= cfg_wdata[4:0];
                gafm_pkg::REG_HEADER_BYTE:  header_byte_reg <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign alarm_cfg.warn_ppm     = warn_ppm_reg;
    assign alarm_cfg.danger_ppm   = danger_ppm_reg;
    assign alarm_cfg.repeat_ticks = repeat_ticks_reg;

    gafm_rx #(
        .FRAME_LEN(FRAME_LEN)
    ) u_rx (
        .aclk(aclk),
        .aresetn(aresetn),
        .step(step),
        .op(op_reg),
        .rx_byte(byte_reg),
        .header_byte(header_byte_reg),
        .rx_result(rx_result)
    );

    gafm_alarm u_alarm (
        .aclk(aclk),
        .aresetn(aresetn),
        .step(step),
        .op(op_reg),
        .power_on(power_reg),
        .rx_result(rx_result),
        .cfg(alarm_cfg),
        .alarm_result(alarm_result)
    );

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= alarm_result;
            status_reg <= rx_result.status;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_cmd_valid    = result_reg.cmd_valid;
    assign m_alarm_cmd    = result_reg.alarm_cmd;
    assign m_relay_action = result_reg.relay_action;
    assign m_ppm_value    = result_reg.ppm_value;
    assign m_display_code = result_reg.display_code;
    assign m_frame_status = status_reg;
    assign m_alarm_level  = result_reg.alarm_level;

endmodule

[src/gafm_rx.sv]
module gafm_rx #(
    parameter int FRAME_LEN = gafm_pkg::FRAME_LEN_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  op,
    input  logic [7:0]            rx_byte,
    input  logic [7:0]            header_byte,
    output gafm_pkg::rx_result_t  rx_result
);

    localparam int IDX_W = $clog2(FRAME_LEN);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] CRC_BYTES = IDX_W'(FRAME_LEN - 2);

    typedef enum logic [3:0] {
        MODE_WAIT    = 4'b0001,
        MODE_COLLECT = 4'b0010,
        MODE_DISCARD = 4'b0100,
        MODE_DONE    = 4'b1000
    } rx_mode_t;

    rx_mode_t         mode_reg, mode_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       store_reg [FRAME_LEN];
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [15:0]      crc_step;
    logic [15:0]      crc_got;

    assign crc_step = gafm_pkg::crc_byte(crc_reg, rx_byte);
    assign crc_got  = {store_reg[FRAME_LEN-1], store_reg[FRAME_LEN-2]};

    always_comb begin
        mode_next = mode_reg;
        count_next = count_reg;
        crc_next = crc_reg;
        wr_en = 1'b0;
        wr_idx = count_reg;
        rx_result.status = gafm_pkg::STATUS_NONE;
        rx_result.ok = 1'b0;
        rx_result.ppm = {store_reg[gafm_pkg::PPM_HI_IDX], store_reg[gafm_pkg::PPM_LO_IDX]};
        if (op == gafm_pkg::OP_BYTE) begin
            unique case (mode_reg)
                MODE_WAIT: begin
                    wr_en = 1'b1;
                    wr_idx = '0;
                    if (rx_byte == header_byte) begin
                        count_next = IDX_W'(1);
                        mode_next = MODE_COLLECT;
                        crc_next = crc_step;
                    end else begin
                        mode_next = MODE_DISCARD;
                    end
                end
                MODE_COLLECT: begin
                    wr_en = 1'b1;
                    if (count_reg < CRC_BYTES) begin
                        crc_next = crc_step;
                    end
                    if (count_reg == LAST_IDX) begin
                        mode_next = MODE_DONE;
                    end else begin
                        count_next = count_reg + IDX_W'(1);
                    end
                end
                MODE_DISCARD, MODE_DONE: begin
                end
                default: begin
                    mode_next = MODE_WAIT;
                end
            endcase
        end else begin
            unique case (mode_reg)
                MODE_WAIT:    rx_result.status = gafm_pkg::STATUS_NO_REPLY;
                MODE_DISCARD: rx_result.status = gafm_pkg::STATUS_BAD_HEADER;
                MODE_COLLECT: rx_result.status = gafm_pkg::STATUS_INCOMPLETE;
                MODE_DONE: begin
                    if (crc_got == crc_reg) begin
                        rx_result.status = gafm_pkg::STATUS_OK;
                        rx_result.ok = 1'b1;
                    end else begin
                        rx_result.status = gafm_pkg::STATUS_CRC_ERROR;
                    end
                end
                default: rx_result.status = gafm_pkg::STATUS_NO_REPLY;
            endcase
            mode_next = MODE_WAIT;
            count_next = '0;
            crc_next = gafm_pkg::CRC_INIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_WAIT;
            count_reg <= '0;
            crc_reg <= gafm_pkg::CRC_INIT;
        end else if (step) begin
            mode_reg <= mode_next;
            count_reg <= count_next;
            crc_reg <= crc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && wr_en) begin
            store_reg[wr_idx] <= rx_byte;
        end
    end

endmodule

[src/gafm_alarm.sv]
module gafm_alarm (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic                    op,
    input  logic                    power_on,
    input  gafm_pkg::rx_result_t    rx_result,
    input  gafm_pkg::alarm_cfg_t    cfg,
    output gafm_pkg::alarm_result_t alarm_result
);

    logic [15:0] ppm_held_reg, ppm_held_next;
    logic [3:0]  display_held_reg, display_held_next;
    logic [1:0]  level_now_reg, level_now_next;
    logic [1:0]  level_prior_reg, level_prior_next;
    logic [4:0]  tick_count_reg, tick_count_next;
    logic        cmd_valid;
    logic [2:0]  alarm_cmd;
    logic [1:0]  relay_action;

    always_comb begin
        ppm_held_next = ppm_held_reg;
        display_held_next = display_held_reg;
        level_now_next = level_now_reg;
        level_prior_next = level_prior_reg;
        tick_count_next = tick_count_reg;
        cmd_valid = 1'b0;
        alarm_cmd = gafm_pkg::CMD_SILENCE;
        relay_action = gafm_pkg::RELAY_NONE;
        if (op == gafm_pkg::OP_TICK) begin
            if (rx_result.ok) begin
                ppm_held_next = rx_result.ppm;
                display_held_next = gafm_pkg::band_code(rx_result.ppm, display_held_reg);
            end
            priority if (!power_on) begin
                tick_count_next = '0;
                level_now_next = gafm_pkg::LEVEL_SAFE;
                level_prior_next = gafm_pkg::LEVEL_SAFE;
                cmd_valid = 1'b1;
                relay_action = gafm_pkg::RELAY_CLOSE;
            end else if (ppm_held_next >= cfg.danger_ppm) begin
                if (level_now_reg != gafm_pkg::LEVEL_DANGER) begin
                    tick_count_next = '0;
                    alarm_cmd = (level_now_reg == gafm_pkg::LEVEL_SAFE &&
                                 level_prior_reg == gafm_pkg::LEVEL_SAFE) ?
                                gafm_pkg::CMD_RAPID_SPEECH : gafm_pkg::CMD_RAPID_BEEP;
                    cmd_valid = 1'b1;
                    relay_action = gafm_pkg::RELAY_OPEN;
                    level_now_next = gafm_pkg::LEVEL_DANGER;
                    level_prior_next = gafm_pkg::LEVEL_DANGER;
                end
            end else if (ppm_held_next >= cfg.warn_ppm) begin
                // entering warning, then counting toward the short beep
                if (level_now_next == gafm_pkg::LEVEL_SAFE &&
                    level_prior_next == gafm_pkg::LEVEL_SAFE) begin
                    level_now_next = gafm_pkg::LEVEL_WARN;
                    tick_count_next = '0;
                    cmd_valid = 1'b1;
                    alarm_cmd = gafm_pkg::CMD_SPEAK;
                    relay_action = gafm_pkg::RELAY_OPEN;
                end
                if (level_now_next == gafm_pkg::LEVEL_WARN &&
                    level_prior_next == gafm_pkg::LEVEL_SAFE) begin
                    if (tick_count_next >= cfg.repeat_ticks) begin
                        tick_count_next = '0;
                        cmd_valid = 1'b1;
                        alarm_cmd = gafm_pkg::CMD_SHORT_BEEP;
                        level_prior_next = gafm_pkg::LEVEL_WARN;
                    end else begin
                        tick_count_next = tick_count_next + 5'd1;
                    end
                end
                // falling back from danger
                if (level_now_next == gafm_pkg::LEVEL_DANGER &&
                    level_prior_next == gafm_pkg::LEVEL_DANGER) begin
                    level_now_next = gafm_pkg::LEVEL_WARN;
                    cmd_valid = 1'b1;
                    alarm_cmd = gafm_pkg::CMD_SHORT_BEEP;
                    level_prior_next = gafm_pkg::LEVEL_WARN;
                end
                if (level_now_next == gafm_pkg::LEVEL_WARN &&
                    level_prior_next == gafm_pkg::LEVEL_DANGER) begin
                    level_prior_next = gafm_pkg::LEVEL_WARN;
                end
            end else begin
                if (level_now_reg != gafm_pkg::LEVEL_SAFE) begin
                    tick_count_next = '0;
                    level_now_next = gafm_pkg::LEVEL_SAFE;
                    level_prior_next = gafm_pkg::LEVEL_SAFE;
                    cmd_valid = 1'b1;
                    relay_action = gafm_pkg::RELAY_CLOSE;
                end
            end
        end
    end

    assign alarm_result.cmd_valid    = cmd_valid;
    assign alarm_result.alarm_cmd    = alarm_cmd;
    assign alarm_result.relay_action = relay_action;
    assign alarm_result.ppm_value    = ppm_held_next;
    assign alarm_result.display_code = display_held_next;
    assign alarm_result.alarm_level  = level_now_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ppm_held_reg <= '0;
            display_held_reg <= '0;
            level_now_reg <= gafm_pkg::LEVEL_SAFE;
            level_prior_reg <= gafm_pkg::LEVEL_SAFE;
            tick_count_reg <= '0;
        end else if (step) begin
            ppm_held_reg <= ppm_held_next;
            display_held_reg <= display_held_next;
            level_now_reg <= level_now_next;
            level_prior_reg <= level_prior_next;
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

[src/gafm_checker.sv]
`include "gas_alarm_frame_monitor_top_defines.svh"

module gafm_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_cmd_valid,
    input logic [2:0]  m_alarm_cmd,
    input logic [1:0]  m_relay_action,
    input logic [15:0] m_ppm_value,
    input logic [2:0]  m_frame_status,
    input logic [1:0]  m_alarm_level
);

    // no command means silence and no relay action
    `GAFM_ASSERT_IMP(a_quiet_without_cmd, m_valid && !m_cmd_valid, m_alarm_cmd == gafm_pkg::CMD_SILENCE && m_relay_action == gafm_pkg::RELAY_NONE)

    // commands only come from tick items
    `GAFM_ASSERT_IMP(a_cmd_only_on_tick, m_valid && m_cmd_valid, m_frame_status != gafm_pkg::STATUS_NONE)

    `GAFM_ASSERT_IMP(a_open_not_safe, m_valid && m_relay_action == gafm_pkg::RELAY_OPEN, m_alarm_level != gafm_pkg::LEVEL_SAFE)

    `GAFM_ASSERT_IMP(a_close_is_safe, m_valid && m_relay_action == gafm_pkg::RELAY_CLOSE, m_alarm_level == gafm_pkg::LEVEL_SAFE)

    `GAFM_ASSERT_NEXT(a_stalled_item_holds, m_valid && !m_ready, m_valid && $stable(m_ppm_value) && $stable(m_alarm_cmd))

endmodule

bind gas_alarm_frame_monitor_top gafm_checker u_gafm_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_cmd_valid(m_cmd_valid),
    .m_alarm_cmd(m_alarm_cmd),
    .m_relay_action(m_relay_action),
    .m_ppm_value(m_ppm_value),
    .m_frame_status(m_frame_status),
    .m_alarm_level(m_alarm_level)
);
